[rtl/alsf_pkg.sv]
package alsf_pkg;

	// Number of wheels handled side by side, one lane each.
	localparam int ALSF_LANES = 4;

	// Configuration register indexes and port widths.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_UPPER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LOWER = 2'd1;
	localparam logic [14:0] SPEED_UPPER_RST = 15'd8000;
	localparam logic signed [15:0] SPEED_LOWER_RST = -16'sd8000;

	// Gain arithmetic in Q0.16: the gain saturates at 0.85 once the jump reaches this knee.
	localparam logic [15:0] GAIN_CAP = 16'd55705;
	localparam logic [16:0] GAIN_KNEE = 17'd26;

	// Reciprocal of three, exact for dividends below 2**17.
	localparam logic [15:0] RECIP3 = 16'd43691;

	typedef struct packed {
		logic signed [15:0] set_front_left;
		logic signed [15:0] set_front_right;
		logic signed [15:0] set_rear_left;
		logic signed [15:0] set_rear_right;
	} alsf_in_t;

	typedef struct packed {
		logic signed [15:0] out_front_left;
		logic signed [15:0] out_front_right;
		logic signed [15:0] out_rear_left;
		logic signed [15:0] out_rear_right;
	} alsf_out_t;

	// Stage enables from the sequencer to every lane.
	typedef struct packed {
		logic load;
		logic gain;
		logic mul;
		logic div;
		logic push;
	} alsf_step_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} alsf_state_t;

	// floor(d * 65536 / 30) for jumps below the knee.
	function automatic logic [15:0] gain_lut(input logic [4:0] d);
		logic [15:0] g;
		case (d)
			5'd0: g = 16'd0;
			5'd1: g = 16'd2184;
			5'd2: g = 16'd4369;
			5'd3: g = 16'd6553;
			5'd4: g = 16'd8738;
			5'd5: g = 16'd10922;
			5'd6: g = 16'd13107;
			5'd7: g = 16'd15291;
			5'd8: g = 16'd17476;
			5'd9: g = 16'd19660;
			5'd10: g = 16'd21845;
			5'd11: g = 16'd24029;
			5'd12: g = 16'd26214;
			5'd13: g = 16'd28398;
			5'd14: g = 16'd30583;
			5'd15: g = 16'd32768;
			5'd16: g = 16'd34952;
			5'd17: g = 16'd37137;
			5'd18: g = 16'd39321;
			5'd19: g = 16'd41506;
			5'd20: g = 16'd43690;
			5'd21: g = 16'd45875;
			5'd22: g = 16'd48059;
			5'd23: g = 16'd50244;
			5'd24: g = 16'd52428;
			5'd25: g = 16'd54613;
			default: g = GAIN_CAP;
		endcase
		return g;
	endfunction

endpackage

[rtl/adaptive_lag_speed_filter_top.sv]
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_stall     in_data (alsf_in_t)
// out       output     out_valid / out_stall   out_data (alsf_out_t)
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Every item passes through accept with clamp, gain, multiply, divide, and the result
// is loaded into the output register; the four wheels run in parallel lanes.
// A new item is accepted only when idle or in the cycle the result is loaded.
// Reset clears the history to zero and sets the speed limits to 8000 and -8000.
// A stalled output holds the finished result; at most one further item waits in the lanes.
// cfg_ready is always high; writes to unknown indexes are ignored.
module adaptive_lag_speed_filter_top
	import alsf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  alsf_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output alsf_out_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	alsf_state_t        state_q;
	alsf_state_t        state_nxt;
	logic [14:0]        upper_q;
	logic signed [15:0] lower_q;
	alsf_step_t         step;
	logic               in_accept;
	logic               out_free;
	logic signed [15:0] set_lane [ALSF_LANES];
	logic signed [15:0] lane_y [ALSF_LANES];

	assign cfg_ready = 1'b1;

	// Speed limit registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= SPEED_UPPER_RST;
			lower_q <= SPEED_LOWER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SPEED_UPPER: upper_q <= cfg_data[14:0];
				REG_SPEED_LOWER: lower_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// The output register is free if empty or if its transfer completes this cycle.
	assign out_free = !out_valid || !out_stall;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and stage enables.
	always_comb begin
		state_nxt = state_q;
		step = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_GAIN: begin
				step.gain = 1'b1;
				state_nxt = ST_MUL;
			end
			ST_MUL: begin
				step.mul = 1'b1;
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				step.div = 1'b1;
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					step.push = 1'b1;
					in_stall = 1'b0;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
		in_accept = in_valid && !in_stall;
		if (in_accept) begin
			step.load = 1'b1;
			state_nxt = ST_GAIN;
		end
	end

	// One lane per wheel.
	assign set_lane[0] = in_data.set_front_left;
	assign set_lane[1] = in_data.set_front_right;
	assign set_lane[2] = in_data.set_rear_left;
	assign set_lane[3] = in_data.set_rear_right;

	for (genvar i = 0; i < ALSF_LANES; i++) begin : g_lane
		alsf_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (step),
			.set_in (set_lane[i]),
			.upper  (upper_q),
			.lower  (lower_q),
			.y      (lane_y[i])
		);
	end

	alsf_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step.push),
		.lane_y    (lane_y),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// An accepted item always starts the gain step next.
	a_accept_to_gain: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == ST_GAIN)
		else $error("accepted item did not enter the gain step");

	// Handing results over always leaves a valid result behind.
	a_push_valid: assert property (@(posedge clk) disable iff (!arst_n)
		step.push |=> out_valid)
		else $error("result handed over but output not valid");

	// A new result only appears after the last step.
	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_DONE)
		else $error("output became valid outside the last step");

	// The divide step is always followed by the last step.
	a_div_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |=> state_q == ST_DONE)
		else $error("divide step not followed by the last step");

endmodule

[rtl/alsf_lane.sv]
module alsf_lane
	import alsf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  alsf_step_t         step,
	input  logic signed [15:0] set_in,
	input  logic [14:0]        upper,
	input  logic signed [15:0] lower,
	output logic signed [15:0] y
);

	logic signed [15:0] set_s1;
	logic [15:0]        gain_s2;
	logic signed [17:0] set3_s2;
	logic signed [18:0] dlt_s2;
	logic signed [35:0] num_s3;
	logic               neg_s4;
	logic [16:0]        hi_s4;
	logic signed [15:0] hist_q [3];

	logic signed [15:0] set_clamp;
	logic signed [16:0] diff;
	logic [16:0]        absd;
	logic [15:0]        gain;
	logic signed [17:0] sum;
	logic signed [17:0] set3;
	logic signed [35:0] num;
	logic [35:0]        mag;
	logic [32:0]        qprod;
	logic [15:0]        q;

	// Clamp the setpoint; the upper limit takes precedence.
	always_comb begin
		if (17'(set_in) > $signed({2'b00, upper})) begin
			set_clamp = $signed({1'b0, upper});
		end else if (set_in < lower) begin
			set_clamp = lower;
		end else begin
			set_clamp = set_in;
		end
	end

	// Gain from the jump against the newest output, and the history sum less three times the setpoint.
	always_comb begin
		diff = 17'(set_s1) - 17'(hist_q[0]);
		absd = diff[16] ? 17'(-diff) : 17'(diff);
		gain = (absd >= GAIN_KNEE) ? GAIN_CAP : gain_lut(absd[4:0]);
		sum = 18'(hist_q[0]) + 18'(hist_q[1]) + 18'(hist_q[2]);
		set3 = 18'(set_s1) + 18'($signed({set_s1, 1'b0}));
	end

	// Numerator rewritten as 3s * 65536 + (sum - 3s) * g, so one multiplier suffices.
	assign num = {{2{set3_s2[17]}}, set3_s2, 16'b0} +
		36'(dlt_s2) * 36'($signed({1'b0, gain_s2}));

	// Magnitude of the numerator; dividing by 65536 is the part-select below.
	assign mag = num_s3[35] ? 36'(-num_s3) : 36'(num_s3);

	// Divide by three through the reciprocal, then restore the sign (truncation towards zero).
	assign qprod = {16'b0, hi_s4} * {17'b0, RECIP3};
	assign q = qprod[32:17];
	assign y = neg_s4 ? $signed(16'(-q)) : $signed(q);

	// Datapath stages, each loaded once per item by the sequencer.
	always_ff @(posedge clk) begin
		if (step.load) begin
			set_s1 <= set_clamp;
		end
		if (step.gain) begin
			gain_s2 <= gain;
			set3_s2 <= set3;
			dlt_s2 <= 19'(sum) - 19'(set3);
		end
		if (step.mul) begin
			num_s3 <= num;
		end
		if (step.div) begin
			neg_s4 <= num_s3[35];
			hi_s4 <= mag[32:16];
		end
	end

	// Three-deep output history, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q[0] <= '0;
			hist_q[1] <= '0;
			hist_q[2] <= '0;
		end else if (step.push) begin
			hist_q[2] <= hist_q[1];
			hist_q[1] <= hist_q[0];
			hist_q[0] <= y;
		end
	end

endmodule

[rtl/alsf_merge.sv]
module alsf_merge
	import alsf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic signed [15:0] lane_y [ALSF_LANES],
	input  logic               out_stall,
	output logic               out_valid,
	output alsf_out_t          out_data
);

	logic      out_valid_q;
	alsf_out_t out_data_q;

	// Output valid: set when the lanes hand over, cleared once the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Gather the lane results into one result item.
	always_ff @(posedge clk) begin
		if (push) begin
			out_data_q.out_front_left <= lane_y[0];
			out_data_q.out_front_right <= lane_y[1];
			out_data_q.out_rear_left <= lane_y[2];
			out_data_q.out_rear_right <= lane_y[3];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule
